// ----- hdl/iyu_pkg.sv -----
// shared types and constants for the imu yaw frame unwrapper
// no dependencies; used by iyu_cfg, iyu_unwrap, imu_yaw_frame_unwrap and the verif files
package iyu_pkg;

  // register word indices, taken from paddr[3:2]
  localparam logic [1:0] REG_SYNC_BYTE  = 2'd0;
  localparam logic [1:0] REG_FRAME_TYPE = 2'd1;
  localparam logic [1:0] REG_JUMP_THR   = 2'd2;

  localparam logic [7:0] SYNC_BYTE_RST  = 8'h55;
  localparam logic [7:0] FRAME_TYPE_RST = 8'h53;
  localparam logic [8:0] JUMP_THR_RST   = 9'd300;

  // frame byte positions, sync byte counts as zero
  localparam logic [2:0] POS_HUNT       = 3'd0;
  localparam logic [2:0] POS_TYPE       = 3'd1;
  localparam logic [2:0] POS_FILL_FIRST = 3'd2;
  localparam logic [2:0] POS_YAW_LOW    = 3'd6;
  localparam logic [2:0] POS_YAW_HIGH   = 3'd7;

  localparam logic [1:0] WRAP_NONE = 2'd0;
  localparam logic [1:0] WRAP_DOWN = 2'd1;
  localparam logic [1:0] WRAP_UP   = 2'd2;

  localparam logic signed [31:0] HEADING_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [8:0] jump_threshold;
    logic [7:0] frame_type;
    logic [7:0] sync_byte;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         wrap_event;
    logic signed [31:0] heading;
  } res_t;

endpackage

// ----- hdl/iyu_cfg.sv -----
// apb register file: sync byte, frame type, jump threshold
// depends on iyu_pkg
module iyu_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output iyu_pkg::cfg_t      cfg
);

  iyu_pkg::cfg_t cfg_r;
  logic          wr_en;

  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte      <= iyu_pkg::SYNC_BYTE_RST;
      cfg_r.frame_type     <= iyu_pkg::FRAME_TYPE_RST;
      cfg_r.jump_threshold <= iyu_pkg::JUMP_THR_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        iyu_pkg::REG_SYNC_BYTE:  cfg_r.sync_byte      <= pwdata[7:0];
        iyu_pkg::REG_FRAME_TYPE: cfg_r.frame_type     <= pwdata[7:0];
        iyu_pkg::REG_JUMP_THR:   cfg_r.jump_threshold <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      iyu_pkg::REG_SYNC_BYTE:  prdata = {24'd0, cfg_r.sync_byte};
      iyu_pkg::REG_FRAME_TYPE: prdata = {24'd0, cfg_r.frame_type};
      iyu_pkg::REG_JUMP_THR:   prdata = {23'd0, cfg_r.jump_threshold};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ----- hdl/iyu_unwrap.sv -----
// yaw scaling and phase unwrap pipeline, holds offset and last heading
// depends on iyu_pkg
module iyu_unwrap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               word_valid,
  input  logic [15:0]        word,
  input  logic [8:0]         jump_threshold,
  output logic               res_valid,
  output iyu_pkg::res_t      res,
  output logic               busy
);

  function automatic logic signed [31:0] clamp34(input logic signed [33:0] v);
    logic signed [33:0] hi;
    hi = $signed({2'b00, iyu_pkg::HEADING_MAX});
    if (v > hi) return iyu_pkg::HEADING_MAX;
    else if (v < -hi) return -iyu_pkg::HEADING_MAX;
    else return v[31:0];
  endfunction

  logic               v1_r, v2_r, v3_r, v4_r;
  logic [15:0]        word_r;
  logic signed [8:0]  deg_r;
  logic signed [32:0] t3_r, t4_r;
  logic [1:0]         ev_r;
  logic signed [31:0] offset_r, offset_nxt;
  logic signed [31:0] last_r;

  logic signed [23:0] prod, biased;
  logic signed [33:0] diff, thr, t_adj;
  logic [1:0]         ev_nxt;
  logic signed [31:0] t_sat;

  // raw*180/32768 truncated toward zero: bias negatives before the shift
  always_comb begin
    prod   = $signed({{8{word_r[15]}}, word_r}) * 24'sd180;
    biased = prod + (prod[23] ? 24'sd32767 : 24'sd0);
  end

  // compare the jump against the last heading (prev is its negation)
  always_comb begin
    thr  = $signed({25'd0, jump_threshold});
    diff = $signed({t3_r[32], t3_r}) + $signed({{2{last_r[31]}}, last_r});
    if (diff > thr) ev_nxt = iyu_pkg::WRAP_DOWN;
    else if (diff < -thr) ev_nxt = iyu_pkg::WRAP_UP;
    else ev_nxt = iyu_pkg::WRAP_NONE;
  end

  always_comb begin
    t_adj      = $signed({t4_r[32], t4_r});
    offset_nxt = offset_r;
    case (ev_r)
      iyu_pkg::WRAP_DOWN: begin
        t_adj      = t_adj - 34'sd360;
        offset_nxt = clamp34($signed({{2{offset_r[31]}}, offset_r}) - 34'sd360);
      end
      iyu_pkg::WRAP_UP: begin
        t_adj      = t_adj + 34'sd360;
        offset_nxt = clamp34($signed({{2{offset_r[31]}}, offset_r}) + 34'sd360);
      end
      default: ;
    endcase
    t_sat = clamp34(t_adj);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      offset_r <= '0;
      last_r   <= '0;
    end else begin
      v1_r <= word_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (v4_r) begin
        offset_r <= offset_nxt;
        last_r   <= -t_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid) word_r <= word;
    if (v1_r) deg_r <= biased[23:15];
    if (v2_r) t3_r <= $signed({offset_r[31], offset_r}) + $signed({{24{deg_r[8]}}, deg_r});
    if (v3_r) begin
      t4_r <= t3_r;
      ev_r <= ev_nxt;
    end
  end

  assign res_valid      = v4_r;
  assign res.heading    = -t_sat;
  assign res.wrap_event = ev_r;
  assign busy           = v1_r || v2_r || v3_r || v4_r;

endmodule

// ----- hdl/imu_yaw_frame_unwrap.sv -----
// Byte-stream parser for inertial sensor angle frames with yaw phase unwrap.
// One input transfer is taken per clock while in_tready is high. The first frame
// of each burst sends its yaw word into a four-stage unwrap pipeline (word
// register, scale, offset add, jump compare); adjust and saturate feed the output
// register that drives out_tdata, and out_tvalid rises when it is loaded.
// in_tready drops only while the parser waits for a high yaw byte and the previous
// heading is still in the pipeline or not yet taken from the output register; the
// next high yaw byte needs an idle marker and a whole new frame before it, so only
// a stalled output can hold off the input.
// Depends on iyu_pkg, iyu_cfg, iyu_unwrap.
module imu_yaw_frame_unwrap (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] idle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] heading, [33:32] wrap_event, [39:34] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  iyu_pkg::cfg_t cfg;
  iyu_pkg::res_t res, out_res_r;
  logic          res_valid, uw_busy;
  logic          in_xfer;
  logic [2:0]    pos_r, pos_nxt;
  logic [7:0]    yaw_low_r;
  logic          done_r, done_nxt;
  logic          word_valid;
  logic          out_tvalid_r;

  assign cfg_pready = 1'b1;

  iyu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // only the frame-completing byte has to wait for the pipeline
  assign in_tready = !((uw_busy || out_tvalid_r) && pos_r == iyu_pkg::POS_YAW_HIGH && !done_r);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    pos_nxt    = pos_r;
    done_nxt   = done_r;
    word_valid = 1'b0;
    if (in_xfer) begin
      if (in_tuser) begin
        pos_nxt  = iyu_pkg::POS_HUNT;
        done_nxt = 1'b0;
      end else if (!done_r) begin
        case (pos_r)
          iyu_pkg::POS_HUNT: begin
            if (in_tdata == cfg.sync_byte) pos_nxt = iyu_pkg::POS_TYPE;
          end
          iyu_pkg::POS_TYPE: begin
            // type match wins over a repeated sync
            if (in_tdata == cfg.frame_type) pos_nxt = iyu_pkg::POS_FILL_FIRST;
            else if (in_tdata == cfg.sync_byte) pos_nxt = iyu_pkg::POS_TYPE;
            else pos_nxt = iyu_pkg::POS_HUNT;
          end
          iyu_pkg::POS_YAW_HIGH: begin
            pos_nxt    = iyu_pkg::POS_HUNT;
            done_nxt   = 1'b1;
            word_valid = 1'b1;
          end
          default: pos_nxt = pos_r + 3'd1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= iyu_pkg::POS_HUNT;
      done_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_low_r <= '0;
    end else if (in_xfer && !in_tuser && !done_r && pos_r == iyu_pkg::POS_YAW_LOW) begin
      yaw_low_r <= in_tdata;
    end
  end

  iyu_unwrap u_unwrap (
    .clk            (clk),
    .rst_n          (rst_n),
    .word_valid     (word_valid),
    .word           ({in_tdata, yaw_low_r}),
    .jump_threshold (cfg.jump_threshold),
    .res_valid      (res_valid),
    .res            (res),
    .busy           (uw_busy)
  );

  // the pipeline holds one heading at most, so the output slot is free here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_res_r <= res;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, out_res_r.wrap_event, out_res_r.heading};

endmodule

// ----- hdl/iyu_checker.sv -----
// port-level checks for imu_yaw_frame_unwrap, attached by bind
// depends on nothing but the top level's ports
module iyu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        cfg_pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // wrap code is never the unused value and padding stays zero
  a_wrap_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'd3 && out_tdata[39:34] == 6'd0)
    else $error("bad wrap code or padding");

  // heading saturates symmetric, never the most negative word
  a_heading_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:0] != 32'h8000_0000)
    else $error("heading outside saturation range");

  // an idle marker restarts the hunt, so the next byte is never held off
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> in_tready)
    else $error("input stalled right after idle marker");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready dropped");

endmodule

bind imu_yaw_frame_unwrap iyu_checker u_iyu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

// ----- verif/imu_yaw_frame_unwrap_chk.sv -----
// checker for imu_yaw_frame_unwrap: follows the input, result and register ports,
// predicts each heading and compares it with what the block sends; needs iyu_pkg
module imu_yaw_frame_unwrap_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] idle
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [31:0] heading, [33:32] wrap_event, [39:34] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEG_HALF_TURN = 180;
  localparam int RAW_HALF_RANGE = 32768;
  localparam longint FULL_TURN = 360;

  iyu_pkg::cfg_t  cfg;
  logic [2:0]     pos;
  logic [7:0]     yaw_lo;
  bit             burst_done;
  int             offset;
  int             last_heading;
  int             fails = 0;
  iyu_pkg::res_t  due_headings[$];

  function automatic int clamp_heading(input longint v);
    if (v > longint'(iyu_pkg::HEADING_MAX)) return iyu_pkg::HEADING_MAX;
    if (v < -longint'(iyu_pkg::HEADING_MAX)) return -iyu_pkg::HEADING_MAX;
    return int'(v);
  endfunction

  // advances the frame parser by one byte; returns 1 when a heading comes out
  function automatic bit parse_rx_byte(input logic [7:0] b, input logic idle,
                                       output iyu_pkg::res_t res);
    bit got = 1'b0;
    int raw;
    int deg;
    longint t;
    longint prev;
    longint thr;
    logic [1:0] ev;
    res = '0;
    if (idle) begin
      pos = iyu_pkg::POS_HUNT;
      burst_done = 1'b0;
    end else if (!burst_done) begin
      case (pos)
        iyu_pkg::POS_HUNT: begin
          if (b == cfg.sync_byte) pos = iyu_pkg::POS_TYPE;
        end
        iyu_pkg::POS_TYPE: begin
          // type match wins even when sync and type are the same byte
          if (b == cfg.frame_type) pos = iyu_pkg::POS_FILL_FIRST;
          else if (b == cfg.sync_byte) pos = iyu_pkg::POS_TYPE;
          else pos = iyu_pkg::POS_HUNT;
        end
        iyu_pkg::POS_YAW_LOW: begin
          yaw_lo = b;
          pos = iyu_pkg::POS_YAW_HIGH;
        end
        iyu_pkg::POS_YAW_HIGH: begin
          raw = $signed({b, yaw_lo});
          deg = raw * DEG_HALF_TURN / RAW_HALF_RANGE;
          t = longint'(offset) + deg;
          prev = -longint'(last_heading);
          thr = longint'(cfg.jump_threshold);
          ev = iyu_pkg::WRAP_NONE;
          if (t - prev > thr) begin
            t = t - FULL_TURN;
            offset = clamp_heading(longint'(offset) - FULL_TURN);
            ev = iyu_pkg::WRAP_DOWN;
          end else if (prev - t > thr) begin
            t = t + FULL_TURN;
            offset = clamp_heading(longint'(offset) + FULL_TURN);
            ev = iyu_pkg::WRAP_UP;
          end
          last_heading = -clamp_heading(t);
          pos = iyu_pkg::POS_HUNT;
          burst_done = 1'b1;
          res.heading = last_heading;
          res.wrap_event = ev;
          got = 1'b1;
        end
        default: pos = pos + 3'd1;
      endcase
    end
    return got;
  endfunction

  always @(posedge clk) begin : watch
    iyu_pkg::res_t fresh;
    iyu_pkg::res_t want;
    logic [31:0]   want_rd;
    if (!rst_n) begin
      cfg.sync_byte = iyu_pkg::SYNC_BYTE_RST;
      cfg.frame_type = iyu_pkg::FRAME_TYPE_RST;
      cfg.jump_threshold = iyu_pkg::JUMP_THR_RST;
      pos = iyu_pkg::POS_HUNT;
      yaw_lo = '0;
      burst_done = 1'b0;
      offset = 0;
      last_heading = 0;
      due_headings.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_headings.size() == 0) begin
          fails++;
          $display("%0t: heading with nothing expected: expected none, got heading %0d wrap %0d",
                   $time, $signed(out_tdata[31:0]), out_tdata[33:32]);
        end else begin
          want = due_headings.pop_front();
          if (out_tdata[31:0] !== want.heading) begin
            fails++;
            $display("%0t: heading mismatch: expected %0d, got %0d",
                     $time, want.heading, $signed(out_tdata[31:0]));
          end
          if (out_tdata[39:32] !== {6'b0, want.wrap_event}) begin
            fails++;
            $display("%0t: wrap_event mismatch: expected %0d, got 0x%02h",
                     $time, want.wrap_event, out_tdata[39:32]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (parse_rx_byte(in_tdata, in_tuser, fresh)) due_headings.push_back(fresh);
      end
      if (cfg_psel && cfg_penable && !cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          iyu_pkg::REG_SYNC_BYTE:  want_rd = {24'd0, cfg.sync_byte};
          iyu_pkg::REG_FRAME_TYPE: want_rd = {24'd0, cfg.frame_type};
          iyu_pkg::REG_JUMP_THR:   want_rd = {23'd0, cfg.jump_threshold};
          default:                 want_rd = 32'd0;
        endcase
        if (cfg_prdata !== want_rd) begin
          fails++;
          $display("%0t: register read mismatch at 0x%01h: expected 0x%08h, got 0x%08h",
                   $time, cfg_paddr, want_rd, cfg_prdata);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          iyu_pkg::REG_SYNC_BYTE:  cfg.sync_byte = cfg_pwdata[7:0];
          iyu_pkg::REG_FRAME_TYPE: cfg.frame_type = cfg_pwdata[7:0];
          iyu_pkg::REG_JUMP_THR:   cfg.jump_threshold = cfg_pwdata[8:0];
          default: ;
        endcase
      end
    end
    fail_count <= fails;
    pending <= due_headings.size();
  end

endmodule

// ----- verif/imu_yaw_frame_unwrap_tb.sv -----
// testbench top for imu_yaw_frame_unwrap: clock, reset, byte bursts, register writes
// and the verdict; needs iyu_pkg, the block under hdl and imu_yaw_frame_unwrap_chk
module imu_yaw_frame_unwrap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1350;
  localparam int PHASES = 7;
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // [0] idle
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] heading, [33:32] wrap_event, [39:34] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int            fail_count;
  int            pending;
  int            sent_items = 0;
  int            quiet = 0;
  bit            in_gaps = 1'b0;
  bit            out_stalls = 1'b0;
  iyu_pkg::cfg_t cur_cfg;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  imu_yaw_frame_unwrap dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  imu_yaw_frame_unwrap_chk chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .fail_count, .pending
  );

  // mostly short pauses, now and then a long one
  function automatic int pause_len(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  initial begin
    out_tready <= 1'b1;
    forever begin
      int n;
      @(posedge clk);
      n = pause_len(out_stalls);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic idle, input bit counted);
    int gap;
    gap = pause_len(in_gaps);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= idle;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (counted) sent_items++;
  endtask

  task automatic send_frame(input logic [15:0] yaw, input bit twice_sync);
    if (twice_sync) send_item(cur_cfg.sync_byte, 1'b0, 1'b1);
    send_item(cur_cfg.sync_byte, 1'b0, 1'b1);
    send_item(cur_cfg.frame_type, 1'b0, 1'b1);
    repeat (4) send_item(8'($urandom), 1'b0, 1'b1);
    send_item(yaw[7:0], 1'b0, 1'b1);
    send_item(yaw[15:8], 1'b0, 1'b1);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(input logic [1:0] idx);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] sync_b, input logic [7:0] type_b,
                            input logic [8:0] thr);
    logic [31:0] junk;
    junk = $urandom;
    // upper bits carry junk that the registers must drop
    reg_write(iyu_pkg::REG_SYNC_BYTE, {junk[31:8], sync_b});
    reg_write(iyu_pkg::REG_FRAME_TYPE, {junk[23:0], type_b});
    reg_write(iyu_pkg::REG_JUMP_THR, {junk[31:9], thr});
    reg_read(iyu_pkg::REG_SYNC_BYTE);
    reg_read(iyu_pkg::REG_FRAME_TYPE);
    reg_read(iyu_pkg::REG_JUMP_THR);
    cur_cfg.sync_byte = sync_b;
    cur_cfg.frame_type = type_b;
    cur_cfg.jump_threshold = thr;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_burst();
    int kind;
    logic [7:0] b;
    logic [15:0] yaw;
    kind = $urandom_range(0, 9);
    in_gaps = ($urandom_range(0, 3) != 0);
    out_stalls = ($urandom_range(0, 3) != 0);
    send_item(8'($urandom), 1'b1, 1'b1);
    if (kind <= 6) begin
      repeat ($urandom_range(0, 3)) begin
        b = 8'($urandom);
        if (b == cur_cfg.sync_byte) b = ~b;
        send_item(b, 1'b0, 1'b1);
      end
      // headings near the half-turn edges make wraps likely
      yaw = 16'($urandom);
      case ($urandom_range(0, 5))
        0: yaw = {8'h7f, yaw[7:0]};
        1: yaw = {8'h80, yaw[7:0]};
        default: ;
      endcase
      send_frame(yaw, $urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 2)) send_item(8'($urandom), 1'b0, 1'b1);
    end else if (kind == 7) begin
      // frame cut short by the next idle
      send_item(cur_cfg.sync_byte, 1'b0, 1'b1);
      send_item(cur_cfg.frame_type, 1'b0, 1'b1);
      repeat ($urandom_range(0, 5)) send_item(8'($urandom), 1'b0, 1'b1);
    end else if (kind == 8) begin
      send_item(cur_cfg.sync_byte, 1'b0, 1'b1);
      b = 8'($urandom);
      while (b == cur_cfg.frame_type || b == cur_cfg.sync_byte) b = b + 8'd1;
      send_item(b, 1'b0, 1'b1);
      repeat ($urandom_range(0, 6)) send_item(8'($urandom), 1'b0, 1'b1);
    end else begin
      repeat ($urandom_range(1, 12))
        send_item(8'($urandom), $urandom_range(0, 7) == 0, 1'b1);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    cur_cfg.sync_byte = iyu_pkg::SYNC_BYTE_RST;
    cur_cfg.frame_type = iyu_pkg::FRAME_TYPE_RST;
    cur_cfg.jump_threshold = iyu_pkg::JUMP_THR_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        out_stalls = 1'b1;
        send_item(8'($urandom), 1'b1, 1'b1);
        // repeated sync, most negative yaw
        send_frame(16'h8000, 1'b1);
        // same burst after its heading: ignored
        send_item(cur_cfg.sync_byte, 1'b0, 1'b1);
        send_item(8'($urandom), 1'b1, 1'b1);
        // jump from one end of the half turn to the other
        send_frame(16'h7fff, 1'b0);
        send_item(8'($urandom), 1'b1, 1'b1);
        // cut off by the idle that opens the next burst
        send_item(cur_cfg.sync_byte, 1'b0, 1'b1);
        send_item(cur_cfg.frame_type, 1'b0, 1'b1);
        send_item(8'($urandom), 1'b0, 1'b1);
      end else begin
        in_tvalid <= 1'b0;
        wait_drained();
        case (ph)
          1: set_config(8'h00, 8'hff, 9'd0);
          2: set_config(8'hff, 8'h00, 9'd359);
          3: set_config(8'haa, 8'haa, 9'd511);
          4: begin
            reg_write(REG_UNUSED, $urandom);
            reg_read(REG_UNUSED);
            set_config(iyu_pkg::SYNC_BYTE_RST, iyu_pkg::FRAME_TYPE_RST,
                       iyu_pkg::JUMP_THR_RST);
          end
          default: set_config(8'($urandom), 8'($urandom), 9'($urandom_range(0, 511)));
        endcase
      end
      while (sent_items < (ph + 1) * ITEM_TARGET / PHASES) random_burst();
    end

    in_tvalid <= 1'b0;
    wait_drained();
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/iyu_pkg.sv
hdl/iyu_cfg.sv
hdl/iyu_unwrap.sv
hdl/imu_yaw_frame_unwrap.sv
hdl/iyu_checker.sv
verif/imu_yaw_frame_unwrap_chk.sv
verif/imu_yaw_frame_unwrap_tb.sv
